### rtl/core/tiq_pkg.sv
package tiq_pkg;

  // Field widths fixed by the item formats
  localparam int unsigned IdW   = 8;
  localparam int unsigned TimeW = 31;

  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

  typedef logic [IdW-1:0]   id_t;
  typedef logic [TimeW-1:0] time_t;
  typedef logic [4:0]       pend_t;

  typedef enum logic {
    OP_SCHEDULE = 1'b0,
    OP_CHECK    = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_SCHEDULED = 2'd0,
    KIND_DROPPED   = 2'd1,
    KIND_FIRED     = 2'd2,
    KIND_NOTHING   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCHED,
    ST_WALK,
    ST_FINISH
  } state_e;

  typedef struct packed {
    op_e   operation;
    id_t   event_id;
    time_t delay;
    time_t current_time;
  } in_t;

  typedef struct packed {
    kind_e result_kind;
    id_t   fired_id;
    logic  last;
    pend_t pending_count;
  } out_t;

  // One stored list entry
  typedef struct packed {
    id_t   id;
    time_t due;
  } entry_t;

endpackage

### rtl/core/tiq_store.sv
module tiq_store #(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrW-1:0]     waddr_i,
  input  tiq_pkg::entry_t      wdata_i,
  input  logic [AddrW-1:0]     raddr_i,
  output tiq_pkg::entry_t      rdata_o
);

  tiq_pkg::entry_t mem_q [Depth];
  tiq_pkg::entry_t rdata_q;

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/timed_event_queue.sv
// Schedule: busy_o is high for one cycle and the single result strobes in the next one.
// Check: one shared read port and due-time comparator walk the held entries, one per cycle.
// The last result of a check strobes as busy_o falls; no stall applies.
// Reset (asynchronous, active low) empties the list; entry storage is not cleared.
module timed_event_queue #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  tiq_pkg::in_t  item_i,
  output logic          busy_o,
  output logic          result_valid_o,
  output tiq_pkg::out_t result_o
);

  localparam int unsigned AddrW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CntW  = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned TimeW_P1 = tiq_pkg::TimeW + 1;

  localparam logic [CntW-1:0] CntMax = CntW'(MAX_ENTRIES);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  tiq_pkg::state_e state_q, state_d;
  tiq_pkg::in_t    item_q, item_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] rd_idx_q, rd_idx_d;
  logic [CntW-1:0] kept_q, kept_d;
  logic [CntW-1:0] rem_q, rem_d;
  logic            rd_vld_q, rd_vld_d;
  logic            held_vld_q, held_vld_d;
  tiq_pkg::id_t    held_id_q, held_id_d;
  logic [CntW-1:0] held_rem_q, held_rem_d;
  logic            out_vld_q, out_vld_d;
  tiq_pkg::out_t   out_q, out_d;

  logic                 accept;
  logic                 mem_we;
  logic [AddrW-1:0]     mem_waddr;
  tiq_pkg::entry_t      mem_wdata;
  tiq_pkg::entry_t      mem_rdata;
  logic [TimeW_P1-1:0]  due_sum;
  tiq_pkg::time_t       due_sat;
  logic                 walk_done;

  assign accept = start_i && (state_q == tiq_pkg::ST_IDLE);
  assign busy_o = (state_q != tiq_pkg::ST_IDLE);

  // Due time, saturated at the largest time
  assign due_sum = {1'b0, item_q.current_time} + {1'b0, item_q.delay};
  assign due_sat = due_sum[TimeW_P1-1] ? tiq_pkg::TimeMax : due_sum[TimeW_P1-2:0];

  assign walk_done = (rd_idx_q == count_q) && !rd_vld_q;

  tiq_store #(
    .Depth (MAX_ENTRIES),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (rd_idx_q[AddrW-1:0]),
    .rdata_o (mem_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tiq_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = (item_i.operation == tiq_pkg::OP_CHECK) ? tiq_pkg::ST_WALK
                                                           : tiq_pkg::ST_SCHED;
        end
      end
      tiq_pkg::ST_SCHED:  state_d = tiq_pkg::ST_IDLE;
      tiq_pkg::ST_WALK: begin
        if (walk_done) begin
          state_d = tiq_pkg::ST_FINISH;
        end
      end
      tiq_pkg::ST_FINISH: state_d = tiq_pkg::ST_IDLE;
      default:            state_d = tiq_pkg::ST_IDLE;
    endcase
  end

  // Datapath and result outputs
  always_comb begin
    item_d     = item_q;
    count_d    = count_q;
    rd_idx_d   = rd_idx_q;
    kept_d     = kept_q;
    rem_d      = rem_q;
    rd_vld_d   = 1'b0;
    held_vld_d = held_vld_q;
    held_id_d  = held_id_q;
    held_rem_d = held_rem_q;
    out_vld_d  = 1'b0;
    out_d      = out_q;
    mem_we     = 1'b0;
    mem_waddr  = count_q[AddrW-1:0];
    mem_wdata  = '{id: item_q.event_id, due: due_sat};

    case (state_q)
      tiq_pkg::ST_IDLE: begin
        // Capture the item and arm the walk
        if (accept) begin
          item_d     = item_i;
          rd_idx_d   = '0;
          kept_d     = '0;
          rem_d      = count_q;
          held_vld_d = 1'b0;
        end
      end

      tiq_pkg::ST_SCHED: begin
        // Append the entry unless the list is full
        out_vld_d           = 1'b1;
        out_d.fired_id      = '0;
        out_d.last          = 1'b1;
        if (count_q < CntMax) begin
          mem_we              = 1'b1;
          count_d             = count_q + CntOne;
          out_d.result_kind   = tiq_pkg::KIND_SCHEDULED;
          out_d.pending_count = tiq_pkg::pend_t'(count_q + CntOne);
        end else begin
          out_d.result_kind   = tiq_pkg::KIND_DROPPED;
          out_d.pending_count = tiq_pkg::pend_t'(count_q);
        end
      end

      tiq_pkg::ST_WALK: begin
        // Issue the next read
        if (rd_idx_q != count_q) begin
          rd_idx_d = rd_idx_q + CntOne;
          rd_vld_d = 1'b1;
        end
        // Fire or compact the entry read last cycle
        if (rd_vld_q) begin
          if (mem_rdata.due <= item_q.current_time) begin
            rem_d      = rem_q - CntOne;
            held_vld_d = 1'b1;
            held_id_d  = mem_rdata.id;
            held_rem_d = rem_q - CntOne;
            // A later fire proves the held one is not the last
            if (held_vld_q) begin
              out_vld_d           = 1'b1;
              out_d.result_kind   = tiq_pkg::KIND_FIRED;
              out_d.fired_id      = held_id_q;
              out_d.last          = 1'b0;
              out_d.pending_count = tiq_pkg::pend_t'(held_rem_q);
            end
          end else begin
            mem_we    = 1'b1;
            mem_waddr = kept_q[AddrW-1:0];
            mem_wdata = mem_rdata;
            kept_d    = kept_q + CntOne;
          end
        end
      end

      tiq_pkg::ST_FINISH: begin
        // Close the walk: final fired result or nothing due
        count_d    = kept_q;
        out_vld_d  = 1'b1;
        out_d.last = 1'b1;
        if (held_vld_q) begin
          out_d.result_kind   = tiq_pkg::KIND_FIRED;
          out_d.fired_id      = held_id_q;
          out_d.pending_count = tiq_pkg::pend_t'(held_rem_q);
        end else begin
          out_d.result_kind   = tiq_pkg::KIND_NOTHING;
          out_d.fired_id      = '0;
          out_d.pending_count = tiq_pkg::pend_t'(count_q);
        end
        held_vld_d = 1'b0;
      end

      default: begin
        held_vld_d = 1'b0;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= tiq_pkg::ST_IDLE;
      count_q    <= '0;
      rd_vld_q   <= 1'b0;
      held_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      count_q    <= count_d;
      rd_vld_q   <= rd_vld_d;
      held_vld_q <= held_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    rd_idx_q   <= rd_idx_d;
    kept_q     <= kept_d;
    rem_q      <= rem_d;
    held_id_q  <= held_id_d;
    held_rem_q <= held_rem_d;
    out_q      <= out_d;
  end

  assign result_valid_o = out_vld_q;
  assign result_o       = out_q;

endmodule
